FILE: src/sha256_byte_stream_hasher_macros.svh
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher assertion macros
// Shared concurrent assertion forms, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA256_BYTE_STREAM_HASHER_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define SHA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Constants and command and status types shared by the controller and the
// datapath, and the round functions used by the datapath.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = 40;

  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_START  = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD  = 3'd7;

  typedef enum logic [1:0] {
    BYTE_IN,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      absorb;
    byte_sel_e byte_sel;
    logic      count_block;
    logic      latch_len;
    logic      load_v;
    logic      round;
    logic [5:0] round_idx;
    logic      fold;
    logic      init;
    logic [2:0] word_idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] count;
  } dp_stat_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    return K_TAB[idx];
  endfunction

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    return IV_TAB[idx];
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

FILE: src/sha256_dp.sv
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Byte packing, 16-word schedule window, round registers, chaining words and
// length counters, driven by controller commands.
// ----------------------------------------------------------------------------
module sha256_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha256_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]          byte_i,
  output sha256_pkg::dp_stat_t stat_o,
  output logic [31:0]         word_o
);

  logic [23:0] acc_q, acc_d;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] chain_q [8];
  logic [5:0]  count_q, count_d;
  logic [63:0] bits_q, bits_d;
  logic [63:0] len_q;

  logic [7:0]  byte_mux;
  logic [2:0]  len_sel;
  logic        push;
  logic        shift;
  logic [31:0] shift_in;
  logic [31:0] new_w;
  logic [31:0] tmp_x;
  logic [31:0] tmp_y;
  logic [31:0] ch;
  logic [31:0] maj;

  // Length bytes go out most significant first, one per buffer position.
  assign len_sel = 3'd7 - count_q[2:0];

  always_comb begin
    case (cmd_i.byte_sel)
      sha256_pkg::BYTE_IN:   byte_mux = byte_i;
      sha256_pkg::BYTE_PAD:  byte_mux = sha256_pkg::PAD_BYTE;
      sha256_pkg::BYTE_ZERO: byte_mux = 8'h00;
      sha256_pkg::BYTE_LEN:  byte_mux = len_q[{len_sel, 3'b000} +: 8];
      default:               byte_mux = 8'h00;
    endcase
  end

  assign push     = cmd_i.absorb && (count_q[1:0] == 2'b11);
  assign shift    = push || cmd_i.round;
  assign new_w    = sha256_pkg::small_sigma1(w_q[14]) + w_q[9] +
                    sha256_pkg::small_sigma0(w_q[1]) + w_q[0];
  assign shift_in = cmd_i.round ? new_w : {acc_q, byte_mux};

  assign ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign tmp_x = v_q[7] + sha256_pkg::big_sigma1(v_q[4]) + ch +
                 sha256_pkg::round_const(cmd_i.round_idx) + w_q[0];
  assign tmp_y = sha256_pkg::big_sigma0(v_q[0]) + maj;

  always_comb begin
    acc_d   = acc_q;
    count_d = count_q;
    bits_d  = bits_q;
    if (cmd_i.absorb) begin
      acc_d   = {acc_q[15:0], byte_mux};
      count_d = count_q + 6'd1;
    end
    if (cmd_i.count_block) begin
      bits_d = bits_q + 64'd512;
    end
    if (cmd_i.init) begin
      count_d = '0;
      bits_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      bits_q  <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= sha256_pkg::iv_word(3'(i));
      end
    end else begin
      count_q <= count_d;
      bits_q  <= bits_d;
      if (cmd_i.init) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= sha256_pkg::iv_word(3'(i));
        end
      end else if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) begin
          chain_q[i] <= chain_q[i] + v_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.latch_len) begin
      // The bit counter is a multiple of 512, so the length's low bits carry the byte count.
      len_q <= {bits_q[63:9], count_q, 3'b000};
    end
    if (shift) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= shift_in;
    end
    if (cmd_i.load_v) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= chain_q[i];
      end
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + tmp_x;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= tmp_x + tmp_y;
    end
  end

  assign stat_o.count = count_q;
  assign word_o       = chain_q[cmd_i.word_idx];

endmodule

FILE: src/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte absorption, padding, the 64 compression rounds and the
// digest word output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_mode_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_last_o,
  output logic [2:0]           out_idx_o,
  input  sha256_pkg::dp_stat_t stat_i,
  output sha256_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD80 = 3'd1;
  localparam logic [2:0] ST_PADZ  = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;
  localparam logic [2:0] ST_FOLD  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] ret_q, ret_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       block_full;

  assign block_full = (stat_i.count == sha256_pkg::LAST_BYTE);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    rnd_d       = rnd_q;
    idx_d       = idx_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    cmd_o.byte_sel  = sha256_pkg::BYTE_IN;
    cmd_o.round_idx = rnd_q;
    cmd_o.word_idx  = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == sha256_pkg::MODE_FINISH) begin
            cmd_o.latch_len = 1'b1;
            state_d         = ST_PAD80;
          end else begin
            cmd_o.absorb = 1'b1;
            if (block_full) begin
              cmd_o.count_block = 1'b1;
              cmd_o.load_v      = 1'b1;
              rnd_d             = '0;
              ret_d             = ST_IDLE;
              state_d           = ST_ROUND;
            end
          end
        end
      end
      ST_PAD80: begin
        cmd_o.absorb   = 1'b1;
        cmd_o.byte_sel = sha256_pkg::BYTE_PAD;
        state_d        = ST_PADZ;
        if (block_full) begin
          cmd_o.load_v = 1'b1;
          rnd_d        = '0;
          ret_d        = ST_PADZ;
          state_d      = ST_ROUND;
        end
      end
      ST_PADZ: begin
        if (stat_i.count == sha256_pkg::LEN_START) begin
          state_d = ST_LEN;
        end else begin
          cmd_o.absorb   = 1'b1;
          cmd_o.byte_sel = sha256_pkg::BYTE_ZERO;
          if (block_full) begin
            cmd_o.load_v = 1'b1;
            rnd_d        = '0;
            ret_d        = ST_PADZ;
            state_d      = ST_ROUND;
          end
        end
      end
      ST_LEN: begin
        cmd_o.absorb   = 1'b1;
        cmd_o.byte_sel = sha256_pkg::BYTE_LEN;
        if (block_full) begin
          cmd_o.load_v = 1'b1;
          rnd_d        = '0;
          ret_d        = ST_OUT;
          state_d      = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == sha256_pkg::LAST_ROUND) begin
          state_d = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        idx_d      = '0;
        state_d    = ret_q;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (idx_q == sha256_pkg::LAST_WORD) begin
            cmd_o.init = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  assign out_last_o = (idx_q == sha256_pkg::LAST_WORD);
  assign out_idx_o  = idx_q;

endmodule

FILE: src/sha256_byte_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a byte message with SHA-256 and streams out the eight digest words.
// ----------------------------------------------------------------------------
// Each request on the input stream either absorbs one message byte (tuser
// low, byte in tdata) or finishes the message (tuser high, tdata ignored).
// The byte that completes a 64-byte block is followed by compression (64
// rounds through a single round unit, then one step that adds into the
// chaining words), during which tready stays low. A finish request pads the
// message byte by byte (0x80, zeros, then the 64-bit big-endian bit length),
// runs one or two compressions, and then offers the eight digest words on
// the output stream, word 0 first, with tlast on the eighth. After the last
// word is taken the hasher is back in its initial state and ready for a new
// message; no input is taken while words are pending.
module sha256_byte_stream_hasher (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] byte_value
  input  logic [sha256_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // [0] mode
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [31:0] hash_word, [34:32] word_index, [39:35] zero
  output logic [sha256_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  // last_word
  output logic                                m_axis_tlast_o
);

  sha256_pkg::dp_cmd_t  cmd;
  sha256_pkg::dp_stat_t stat;
  logic [31:0]          word;
  logic [2:0]           out_idx;

  // The controller owns the handshakes; the datapath only follows commands.
  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_mode_i   (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_last_o  (m_axis_tlast_o),
    .out_idx_o   (out_idx),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sha256_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .byte_i (s_axis_tdata_i),
    .stat_o (stat),
    .word_o (word)
  );

  // Digest words come straight from the chaining registers, which hold still
  // while the output request is pending.
  assign m_axis_tdata_o = {5'b00000, out_idx, word};

endmodule

FILE: src/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Watches the stream ports of the hasher over time.
// ----------------------------------------------------------------------------
`include "sha256_byte_stream_hasher_macros.svh"

module sha256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o
);

  logic       out_take;
  logic       out_more;
  logic       out_done;
  logic [2:0] out_idx;
  logic [2:0] next_idx;
  logic       idx_is_last;

  assign out_take    = m_axis_tvalid_o && m_axis_tready_i;
  assign out_more    = out_take && !m_axis_tlast_o;
  assign out_done    = out_take && m_axis_tlast_o;
  assign out_idx     = m_axis_tdata_o[34:32];
  assign next_idx    = out_idx + 3'd1;
  assign idx_is_last = (out_idx == sha256_pkg::LAST_WORD);

  // No input is taken while digest words are pending.
  `SHA_ASSERT_NOW(a_busy_while_emitting, m_axis_tvalid_o, !s_axis_tready_o, "ready while busy")
  `SHA_ASSERT_NOW(a_last_on_word7, m_axis_tvalid_o, m_axis_tlast_o == idx_is_last, "bad tlast")
  `SHA_ASSERT_NEXT(a_idx_step, out_more, m_axis_tvalid_o && out_idx == $past(next_idx), "idx skip")
  `SHA_ASSERT_NEXT(a_idle_after, out_done, s_axis_tready_o && !m_axis_tvalid_o, "not idle")

endmodule

bind sha256_byte_stream_hasher sha256_checker u_sha256_checker (.*);
